[rtl/core/srb_pkg.sv]
// Shared constants, codes and control structs for the sequence reorder buffer.
package srb_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int SEQ_W      = 31;
  localparam int TAG_W      = 16;
  localparam int SSEQ_W     = 32;
  localparam int OCC_W      = 6;
  localparam int STAT_W     = 3;
  localparam int OP_W       = 2;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_RECV  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_POPPED   = 3'd3,
    STAT_NONE     = 3'd4,
    STAT_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_WALK
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    ins;
    logic    pop;
    logic    clr;
    logic    walk;
    logic    emit;
    status_t status;
  } srb_cmd_t;

  typedef struct packed {
    op_t  op;
    logic stale;
    logic dup;
    logic full;
    logic pop_ok;
    logic out_free;
  } srb_stat_t;

endpackage

[rtl/core/srb_in_if.sv]
// Input channel interface: operation and item fields with valid/ready.
interface srb_in_if;
  logic                            valid;
  logic                            ready;
  logic [srb_pkg::OP_W-1:0]        op;
  logic [srb_pkg::SEQ_W-1:0]       seq_id;
  logic [srb_pkg::TAG_W-1:0]       payload_tag;
  logic signed [srb_pkg::SSEQ_W-1:0] last_processed_seq;

  modport source (output valid, op, seq_id, payload_tag, last_processed_seq, input ready);
  modport sink   (input valid, op, seq_id, payload_tag, last_processed_seq, output ready);
endinterface

[rtl/core/srb_out_if.sv]
// Result channel interface: status and list snapshot with valid/ready.
interface srb_out_if;
  logic                              valid;
  logic                              ready;
  logic [srb_pkg::STAT_W-1:0]        status;
  logic signed [srb_pkg::SSEQ_W-1:0] out_seq;
  logic [srb_pkg::TAG_W-1:0]         out_tag;
  logic signed [srb_pkg::SSEQ_W-1:0] head_seq;
  logic signed [srb_pkg::SSEQ_W-1:0] last_contiguous_seq;
  logic [srb_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, status, out_seq, out_tag, head_seq, last_contiguous_seq,
                  occupancy, input ready);
  modport sink   (input valid, status, out_seq, out_tag, head_seq, last_contiguous_seq,
                  occupancy, output ready);
endinterface

[rtl/core/srb_ctrl.sv]
// Controller state machine: sequences capture, list update and result load.
module srb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srb_pkg::srb_stat_t stat,
  output srb_pkg::srb_cmd_t  cmd
);
  import srb_pkg::*;

  state_t state_r, state_nxt;
  logic   recv_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign recv_ok = (stat.op == OP_RECV) && !stat.stale;

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.ins     = 1'b0;
    cmd.pop     = 1'b0;
    cmd.clr     = 1'b0;
    cmd.walk    = 1'b0;
    cmd.emit    = 1'b0;
    case (stat.op)
      OP_RECV: begin
        if (stat.stale || stat.dup) cmd.status = STAT_DUP;
        else if (stat.full)         cmd.status = STAT_FULL;
        else                        cmd.status = STAT_INSERTED;
      end
      OP_POP:   cmd.status = stat.pop_ok ? STAT_POPPED : STAT_NONE;
      OP_CLEAR: cmd.status = STAT_CLEARED;
      default:  cmd.status = STAT_NONE;
    endcase
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_UPD: begin
        cmd.ins = recv_ok && !stat.dup && !stat.full;
        cmd.pop = (stat.op == OP_POP) && stat.pop_ok;
        cmd.clr = (stat.op == OP_CLEAR);
      end
      S_WALK: begin
        cmd.emit = stat.out_free;
        cmd.walk = stat.out_free && recv_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/srb_dpath.sv]
// Datapath: sorted shift-register list, contiguity walk and result register.
module srb_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [srb_pkg::OP_W-1:0]          in_op,
  input  logic [srb_pkg::SEQ_W-1:0]         in_seq,
  input  logic [srb_pkg::TAG_W-1:0]         in_tag,
  input  logic signed [srb_pkg::SSEQ_W-1:0] in_lastp,
  input  srb_pkg::srb_cmd_t                 cmd,
  output srb_pkg::srb_stat_t                stat,
  srb_out_if.source                         out_chan
);
  import srb_pkg::*;

  logic [SEQ_W-1:0]         eseq_r   [LIST_DEPTH];
  logic [TAG_W-1:0]         etag_r   [LIST_DEPTH];
  logic [SEQ_W-1:0]         eseq_nxt [LIST_DEPTH];
  logic [TAG_W-1:0]         etag_nxt [LIST_DEPTH];
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SSEQ_W-1:0] cont_r;

  op_t                      op_r;
  logic [SEQ_W-1:0]         seq_r;
  logic [TAG_W-1:0]         tag_r;
  logic [LIST_DEPTH-1:0]    lt_r;
  logic                     stale_r, dup_r, full_r, popok_r;
  logic [SEQ_W-1:0]         pseq_r;
  logic [TAG_W-1:0]         ptag_r;

  logic                     ov_r;
  status_t                  ostat_r;
  logic signed [SSEQ_W-1:0] oseq_r, ohead_r, ocont_r;
  logic [TAG_W-1:0]         otag_r;
  logic [OCC_W-1:0]         oocc_r;

  logic [LIST_DEPTH-1:0]    held_c, lt_c, eq_c;
  logic                     stale_c, popok_c, full_c;
  logic signed [SSEQ_W:0]   lastp1_c;

  logic [LIST_DEPTH-1:0]    adj_c, walked_c, sel_c, mask_c;
  logic                     ok0_c;
  logic [SEQ_W-1:0]         wseq_c;
  logic signed [SSEQ_W-1:0] walk_cont_c;

  // compares of the incoming item against the held list
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      held_c[i] = CNT_W'(i) < cnt_r;
      lt_c[i]   = held_c[i] && (eseq_r[i] < in_seq);
      eq_c[i]   = held_c[i] && (eseq_r[i] == in_seq);
    end
    stale_c  = $signed({2'b00, in_seq}) <= $signed({cont_r[SSEQ_W-1], cont_r});
    lastp1_c = $signed({in_lastp[SSEQ_W-1], in_lastp}) + 33'sd1;
    popok_c  = (cnt_r != '0) && ($signed({2'b00, eseq_r[0]}) == lastp1_c);
    full_c   = cnt_r == CNT_W'(LIST_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_op);
      seq_r   <= in_seq;
      tag_r   <= in_tag;
      lt_r    <= lt_c;
      stale_r <= stale_c;
      dup_r   <= |eq_c;
      full_r  <= full_c;
      popok_r <= popok_c;
    end
  end

  // sorted insert shifts the tail up; pop shifts everything down
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      eseq_nxt[i] = eseq_r[i];
      etag_nxt[i] = etag_r[i];
    end
    if (cmd.ins) begin
      if (!lt_r[0]) begin
        eseq_nxt[0] = seq_r;
        etag_nxt[0] = tag_r;
      end
      for (int i = 1; i < LIST_DEPTH; i++) begin
        if (!lt_r[i]) begin
          eseq_nxt[i] = lt_r[i-1] ? seq_r : eseq_r[i-1];
          etag_nxt[i] = lt_r[i-1] ? tag_r : etag_r[i-1];
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        eseq_nxt[i] = eseq_r[i+1];
        etag_nxt[i] = etag_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      eseq_r[i] <= eseq_nxt[i];
      etag_r[i] <= etag_nxt[i];
    end
    if (cmd.pop) begin
      pseq_r <= eseq_r[0];
      ptag_r <= etag_r[0];
    end
  end

  // contiguity walk: list is strictly ascending, so past the head the walk
  // continues only through neighbors that differ by one
  always_comb begin
    adj_c[0] = 1'b1;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      adj_c[i] = (CNT_W'(i) < cnt_r) &&
                 ({1'b0, eseq_r[i]} == ({1'b0, eseq_r[i-1]} + 32'd1));
    end
    ok0_c = (cnt_r != '0) &&
            ($signed({2'b00, eseq_r[0]}) <= ($signed({cont_r[SSEQ_W-1], cont_r}) + 33'sd1));
    for (int i = 0; i < LIST_DEPTH; i++) begin
      mask_c[i]   = 1'b0;
      walked_c[i] = 1'b0;
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      mask_c      = {LIST_DEPTH{1'b1}} >> (LIST_DEPTH - 1 - i);
      walked_c[i] = ok0_c && (&(adj_c | ~mask_c));
    end
    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
      sel_c[i] = walked_c[i] && !walked_c[i+1];
    end
    sel_c[LIST_DEPTH-1] = walked_c[LIST_DEPTH-1];
    wseq_c = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      wseq_c = wseq_c | (sel_c[i] ? eseq_r[i] : '0);
    end
    walk_cont_c = ok0_c ? $signed({1'b0, wseq_c}) : cont_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cont_r <= '1;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.ins)      cnt_r <= cnt_r + CNT_W'(1);
      else if (cmd.pop) cnt_r <= cnt_r - CNT_W'(1);
      if (cmd.clr)       cont_r <= '1;
      else if (cmd.walk) cont_r <= walk_cont_c;
      if (cmd.emit)               ov_r <= 1'b1;
      else if (out_chan.ready)    ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ostat_r <= cmd.status;
      oseq_r  <= (cmd.status == STAT_POPPED) ? $signed({1'b0, pseq_r}) : '1;
      otag_r  <= (cmd.status == STAT_POPPED) ? ptag_r : '0;
      ohead_r <= (cnt_r != '0) ? $signed({1'b0, eseq_r[0]}) : '1;
      ocont_r <= cmd.walk ? walk_cont_c : cont_r;
      oocc_r  <= OCC_W'(cnt_r);
    end
  end

  assign stat.op       = op_r;
  assign stat.stale    = stale_r;
  assign stat.dup      = dup_r;
  assign stat.full     = full_r;
  assign stat.pop_ok   = popok_r;
  assign stat.out_free = !ov_r || out_chan.ready;

  assign out_chan.valid               = ov_r;
  assign out_chan.status              = ostat_r;
  assign out_chan.out_seq             = oseq_r;
  assign out_chan.out_tag             = otag_r;
  assign out_chan.head_seq            = ohead_r;
  assign out_chan.last_contiguous_seq = ocont_r;
  assign out_chan.occupancy           = oocc_r;

endmodule

[rtl/core/sequence_reorder_buffer.sv]
// Top level of the sequence reorder buffer: controller plus list datapath.
//
//   channel   dir  fields
//   in_chan   in   op, seq_id, payload_tag, last_processed_seq
//   out_chan  out  status, out_seq, out_tag, head_seq, last_contiguous_seq, occupancy
//
// Each item passes through three steps: compare against the list, shift-register list
// update, contiguity walk with result load.
// A result waiting in the output register stalls the walk state; a new
// transfer is taken once the controller is back in idle.
// Reset empties the list and sets the contiguous number to -1; no clearing pass.
module sequence_reorder_buffer (
  input logic       clk,
  input logic       rst_n,
  srb_in_if.sink    in_chan,
  srb_out_if.source out_chan
);
  import srb_pkg::*;

  srb_cmd_t  cmd;
  srb_stat_t stat;
  logic      in_ready;

  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srb_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_op    (in_chan.op),
    .in_seq   (in_chan.seq_id),
    .in_tag   (in_chan.payload_tag),
    .in_lastp (in_chan.last_processed_seq),
    .cmd      (cmd),
    .stat     (stat),
    .out_chan (out_chan)
  );

  assign in_chan.ready = in_ready;

endmodule

[bench/srb_reorder_checker.sv]
// Result checker for the sequence reorder buffer: tracks the sorted list, predicts and compares.
module srb_reorder_checker (
  input  logic clk,
  input  logic rst_n,
  srb_in_if    in_mon,
  srb_out_if   out_mon,
  output int   error_count,
  output int   open_count
);
  import srb_pkg::*;

  typedef struct {
    status_t                  status;
    logic signed [SSEQ_W-1:0] out_seq;
    logic [TAG_W-1:0]         out_tag;
    logic signed [SSEQ_W-1:0] head_seq;
    logic signed [SSEQ_W-1:0] contig_seq;
    logic [OCC_W-1:0]         occupancy;
  } reorder_result_t;

  logic [SEQ_W-1:0] list_seq [LIST_DEPTH];
  logic [TAG_W-1:0] list_tag [LIST_DEPTH];
  int               list_len;
  longint           contig;
  int               result_idx;
  reorder_result_t  awaited_results[$];

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_idx, name, got, want));
    end
  endtask

  // Extend the contiguous number from the head while the next entry does not skip.
  function automatic void walk_contig();
    for (int i = 0; i < list_len; i++) begin
      if (longint'({1'b0, list_seq[i]}) > contig + 1) break;
      contig = longint'({1'b0, list_seq[i]});
    end
  endfunction

  function automatic status_t insert_item(logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag);
    int pos;
    bit seen;
    pos  = 0;
    seen = 1'b0;
    if (longint'({1'b0, seq}) <= contig) return STAT_DUP;
    for (int k = 0; k < list_len; k++) begin
      if (list_seq[k] == seq) seen = 1'b1;
    end
    if (seen) begin
      walk_contig();
      return STAT_DUP;
    end
    if (list_len >= LIST_DEPTH) begin
      walk_contig();
      return STAT_FULL;
    end
    while (pos < list_len && list_seq[pos] < seq) pos++;
    for (int k = list_len; k > pos; k--) begin
      list_seq[k] = list_seq[k-1];
      list_tag[k] = list_tag[k-1];
    end
    list_seq[pos] = seq;
    list_tag[pos] = tag;
    list_len++;
    walk_contig();
    return STAT_INSERTED;
  endfunction

  function automatic reorder_result_t step_list(op_t op, logic [SEQ_W-1:0] seq,
                                                logic [TAG_W-1:0] tag,
                                                logic signed [SSEQ_W-1:0] lastp);
    reorder_result_t r;
    r.status  = STAT_NONE;
    r.out_seq = -1;
    r.out_tag = '0;
    case (op)
      OP_RECV: r.status = insert_item(seq, tag);
      OP_POP: begin
        if (list_len > 0 && longint'({1'b0, list_seq[0]}) == longint'(lastp) + 1) begin
          r.out_seq = {1'b0, list_seq[0]};
          r.out_tag = list_tag[0];
          for (int k = 1; k < list_len; k++) begin
            list_seq[k-1] = list_seq[k];
            list_tag[k-1] = list_tag[k];
          end
          list_len--;
          r.status = STAT_POPPED;
        end
      end
      OP_CLEAR: begin
        contig   = -1;
        r.status = STAT_CLEARED;
      end
      default: ;
    endcase
    r.head_seq   = (list_len > 0) ? {1'b0, list_seq[0]} : -1;
    r.contig_seq = contig[SSEQ_W-1:0];
    r.occupancy  = OCC_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    reorder_result_t want;
    if (!rst_n) begin
      list_len = 0;
      contig   = -1;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected, status %0d",
                                    result_idx, out_mon.status));
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(out_mon.status), 64'(want.status));
          check_field("out_seq", 64'(out_mon.out_seq), 64'(want.out_seq));
          check_field("out_tag", 64'(out_mon.out_tag), 64'(want.out_tag));
          check_field("head_seq", 64'(out_mon.head_seq), 64'(want.head_seq));
          check_field("last_contiguous_seq", 64'(out_mon.last_contiguous_seq),
                      64'(want.contig_seq));
          check_field("occupancy", 64'(out_mon.occupancy), 64'(want.occupancy));
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results.push_back(step_list(op_t'(in_mon.op), in_mon.seq_id,
                                            in_mon.payload_tag, in_mon.last_processed_seq));
      end
    end
    open_count <= awaited_results.size();
  end

endmodule

[bench/sequence_reorder_buffer_test.sv]
// Testbench top for the sequence reorder buffer: stimulus, flow control and verdict.
module sequence_reorder_buffer_test;
  import srb_pkg::*;

  localparam int unsigned SEQ_MAX     = 32'h7FFF_FFFF;
  localparam int          ITEM_TARGET = 1820;

  logic        clk;
  logic        rst_n;
  int          error_count;
  int          open_count;
  int          op_count [4];
  int          driven;
  bit          in_burst;
  bit          out_burst;
  int unsigned held_q[$];   // sequence numbers believed to be held, ascending
  int unsigned seq_floor;   // above every number received since the last clear

  srb_in_if  in_chan();
  srb_out_if out_chan();

  sequence_reorder_buffer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  srb_reorder_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .error_count(error_count),
    .open_count (open_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_item(op_t op, int unsigned seq, logic [TAG_W-1:0] tag,
                           logic signed [SSEQ_W-1:0] lastp);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid              <= 1'b1;
    in_chan.op                 <= op;
    in_chan.seq_id             <= seq[SEQ_W-1:0];
    in_chan.payload_tag        <= tag;
    in_chan.last_processed_seq <= lastp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    op_count[op]++;
    driven++;
  endtask

  task automatic send_receive(int unsigned seq);
    int pos;
    bit present;
    pos     = 0;
    present = 1'b0;
    send_item(OP_RECV, seq, TAG_W'($urandom), $urandom);
    foreach (held_q[k]) begin
      if (held_q[k] == seq) present = 1'b1;
    end
    // full drops stay listed too; a pop of a missing number just answers nothing ready
    while (pos < held_q.size() && held_q[pos] < seq) pos++;
    if (!present) held_q.insert(pos, seq);
    if (seq >= seq_floor) seq_floor = seq + 1;
  endtask

  task automatic pop_head();
    if (held_q.size() == 0) return;
    send_item(OP_POP, $urandom, TAG_W'($urandom), held_q[0] - 1);
    void'(held_q.pop_front());
  endtask

  task automatic send_noise();
    op_t                      op;
    logic signed [SSEQ_W-1:0] lastp;
    op    = op_t'($urandom_range(0, 3));
    lastp = $urandom;
    if ($urandom_range(0, 7) == 0) lastp = -1;
    if (held_q.size() > 0 && $urandom_range(0, 3) == 0) lastp = held_q[0];
    if (held_q.size() > 0 && lastp == held_q[0] - 1) lastp = held_q[0];
    if (op == OP_RECV) begin
      if (held_q.size() > 0 && $urandom_range(0, 1) == 0) begin
        send_receive(held_q[$urandom_range(0, held_q.size() - 1)]);
      end else if (seq_floor > 0) begin
        send_receive($urandom_range(0, seq_floor - 1));
      end else begin
        send_item(OP_RECV, 0, TAG_W'($urandom), lastp);
        held_q.push_front(0);
        seq_floor = 1;
      end
    end else begin
      send_item(op, $urandom, TAG_W'($urandom), lastp);
    end
  endtask

  // One burst of new numbers above everything seen, received in random order
  // with duplicates, noise and in-order pops mixed in.
  task automatic run_session(bit overfill);
    int unsigned vals[$];
    int unsigned n, base, room, need, offset, tmp;
    int          j, pick;
    bit          dense;
    n      = overfill ? LIST_DEPTH + $urandom_range(1, 6)
                      : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 32 : 10);
    need   = 2 * n + 2;
    room   = (seq_floor > SEQ_MAX) ? 0 : SEQ_MAX - seq_floor;
    dense  = 1'b0;
    offset = 0;
    if (room < need + 16) begin
      while (held_q.size() > 0) pop_head();
      send_item(OP_CLEAR, $urandom, TAG_W'($urandom), $urandom);
      seq_floor = 0;
      room      = SEQ_MAX;
    end
    case ($urandom_range(0, 7))
      0: begin
        base  = SEQ_MAX - n + 1;
        dense = 1'b1;
      end
      1, 2: base = seq_floor + $urandom_range(0, room - need);
      default: base = seq_floor + $urandom_range(0, 2);
    endcase
    for (int k = 0; k < n; k++) begin
      vals.push_back(base + offset);
      offset += (!dense && $urandom_range(0, 7) == 0) ? 2 : 1;
    end
    if ($urandom_range(0, 2) != 0) begin
      for (int k = n - 1; k > 0; k--) begin
        j       = $urandom_range(0, k);
        tmp     = vals[k];
        vals[k] = vals[j];
        vals[j] = tmp;
      end
    end
    foreach (vals[k]) begin
      send_receive(vals[k]);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        pop_head();
      end else if (pick == 2 && held_q.size() > 0) begin
        send_receive(held_q[$urandom_range(0, held_q.size() - 1)]);
      end else if (pick == 3) begin
        send_noise();
      end
    end
    if (overfill || $urandom_range(0, 2) != 0) begin
      while (held_q.size() > 0) pop_head();
    end
  endtask

  initial begin
    int out_stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      out_stall = out_burst ? 0 : $urandom_range(0, 9);
      if (out_stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (out_stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit first_session;
    rst_n                      = 1'b0;
    in_chan.valid              = 1'b0;
    in_chan.op                 = OP_NOP;
    in_chan.seq_id             = '0;
    in_chan.payload_tag        = '0;
    in_chan.last_processed_seq = '0;
    driven                     = 0;
    seq_floor                  = 0;
    first_session              = 1'b1;
    foreach (op_count[k]) op_count[k] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_RECV, 0, 16'hFFFF, 0);
    send_item(OP_RECV, 0, 16'h0001, 0);            // stale
    send_item(OP_RECV, 2, 16'h0000, 0);
    send_item(OP_RECV, 2, 16'h1234, 0);            // held duplicate
    send_item(OP_RECV, 1, 16'h5A5A, 0);
    send_item(OP_POP, 0, 0, -1);
    send_item(OP_POP, 0, 0, 5);                    // head not next
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_RECV, 1, 16'hC3C3, 0);            // duplicate, walk stops at head
    send_item(OP_RECV, SEQ_MAX, 16'hA5A5, 0);
    send_item(OP_RECV, SEQ_MAX - 1, 16'h0F0F, 0);
    send_item(OP_POP, 0, 0, 0);
    send_item(OP_POP, 0, 0, 1);
    send_item(OP_POP, 0, 0, SEQ_MAX - 2);
    send_item(OP_POP, 0, 0, SEQ_MAX - 1);
    send_item(OP_POP, 0, 0, SEQ_MAX);              // empty list
    send_item(OP_POP, 0, 0, -1);
    send_item(OP_NOP, SEQ_MAX, 16'hFFFF, -1);
    send_item(OP_POP, 0, 0, 32'sh8000_0000);

    while (driven < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        run_session(first_session || $urandom_range(0, 5) == 0);
        first_session = 1'b0;
      end
    end
    in_chan.valid <= 1'b0;

    while (open_count != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    $display("Summary: %0d transfers in: %0d receive, %0d pop, %0d clear, %0d no-op",
             driven, op_count[OP_RECV], op_count[OP_POP], op_count[OP_CLEAR],
             op_count[OP_NOP]);
    $display("Summary: %0d mismatches, %0d results outstanding", error_count, open_count);
    if (error_count == 0 && open_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sequence_reorder_buffer.f]
rtl/core/srb_pkg.sv
rtl/core/srb_in_if.sv
rtl/core/srb_out_if.sv
rtl/core/srb_ctrl.sv
rtl/core/srb_dpath.sv
rtl/core/sequence_reorder_buffer.sv
bench/srb_reorder_checker.sv
bench/sequence_reorder_buffer_test.sv
